### src/ritoa_pkg.sv
// Shared types, constants and digit glyph lookup for the radix integer-to-ASCII unit.
package ritoa_pkg;

  localparam int IN_W       = 32;
  localparam int CHAR_W     = 7;
  localparam int BASE_W     = 6;
  localparam int DIGIT_W    = 6;
  localparam int COUNT_W    = 6;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 6;
  localparam int DIV_STEP   = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_NUMBER_BASE = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_SIGNED_MODE = CFG_IDX_W'(1);

  localparam logic [BASE_W-1:0] BASE_MIN   = BASE_W'(2);
  localparam logic [BASE_W-1:0] BASE_MAX   = BASE_W'(36);
  localparam logic [BASE_W-1:0] BASE_RESET = BASE_W'(10);

  localparam logic [CHAR_W-1:0] CHAR_ZERO   = CHAR_W'(48);
  localparam logic [CHAR_W-1:0] CHAR_LETTER = CHAR_W'(87);

  typedef struct packed {
    logic [BASE_W-1:0] base;
    logic              signed_mode;
  } cfg_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIV,
    BK_EMIT
  } back_state_t;

  function automatic logic [CHAR_W-1:0] glyph(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] c;
    if (d < DIGIT_W'(10)) begin
      c = CHAR_ZERO + CHAR_W'(d);
    end else if (d < DIGIT_W'(36)) begin
      c = CHAR_LETTER + CHAR_W'(d);
    end else begin
      c = CHAR_ZERO;
    end
    return c;
  endfunction

endpackage

### src/ritoa_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ritoa_ram #(
  parameter int WIDTH = 6,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

### src/ritoa_queue.sv
// Two-entry queue between the classifying front end and the conversion back end.
module ritoa_queue #(
  parameter int WIDTH = 33
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic             pop_valid,
  output logic [WIDTH-1:0] pop_data
);

  logic [WIDTH-1:0] slot_r [2];
  logic             wr_r, wr_nxt;
  logic             rd_r, rd_nxt;
  logic [1:0]       count_r, count_nxt;

  always_comb begin
    wr_nxt    = wr_r ^ push;
    rd_nxt    = rd_r ^ pop;
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 2'd1;
    end else if (!push && pop) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r    <= 1'b0;
      rd_r    <= 1'b0;
      count_r <= 2'd0;
    end else begin
      wr_r    <= wr_nxt;
      rd_r    <= rd_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_r] <= push_data;
    end
  end

  assign full      = (count_r == 2'd2);
  assign pop_valid = (count_r != 2'd0);
  assign pop_data  = slot_r[rd_r];

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r != 2'd3)
    else $error("queue count out of range");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> count_r != 2'd0)
    else $error("pop from empty queue");

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    push && !pop |-> count_r != 2'd2)
    else $error("push into full queue");

endmodule

### src/ritoa_front.sv
// Front end: configuration registers, item intake and sign classification.
module ritoa_front #(
  parameter int VALUE_BITS = 32
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [ritoa_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ritoa_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [ritoa_pkg::IN_W-1:0]        in_value,
  output ritoa_pkg::cfg_t                   cfg,
  output logic                              push,
  output logic [VALUE_BITS:0]               push_data,
  input  logic                              full
);

  ritoa_pkg::cfg_t          cfg_r, cfg_nxt;
  logic [ritoa_pkg::BASE_W-1:0] base_wr;
  logic [VALUE_BITS-1:0]    word;
  logic [VALUE_BITS-1:0]    mag;
  logic                     neg;

  always_comb begin
    base_wr = cfg_wdata[ritoa_pkg::BASE_W-1:0];
    if (base_wr < ritoa_pkg::BASE_MIN) begin
      base_wr = ritoa_pkg::BASE_MIN;
    end else if (base_wr > ritoa_pkg::BASE_MAX) begin
      base_wr = ritoa_pkg::BASE_MAX;
    end
  end

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        ritoa_pkg::CFG_NUMBER_BASE: cfg_nxt.base = base_wr;
        ritoa_pkg::CFG_SIGNED_MODE: cfg_nxt.signed_mode = cfg_wdata[0];
        default: cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.base        <= ritoa_pkg::BASE_RESET;
      cfg_r.signed_mode <= 1'b1;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  always_comb begin
    word = VALUE_BITS'(in_value);
    neg  = cfg_r.signed_mode & word[VALUE_BITS-1];
    mag  = neg ? (~word + VALUE_BITS'(1)) : word;
  end

  assign cfg       = cfg_r;
  assign in_stall  = full;
  assign push      = in_valid && !full;
  assign push_data = {neg, mag};

  a_base_range: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_r.base >= ritoa_pkg::BASE_MIN && cfg_r.base <= ritoa_pkg::BASE_MAX)
    else $error("radix register out of range");

  a_neg_signed: assert property (@(posedge clk) disable iff (!rst_n)
    push && push_data[VALUE_BITS] |-> cfg_r.signed_mode)
    else $error("negative flag set in unsigned mode");

  a_base_clamp: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we && cfg_index == ritoa_pkg::CFG_NUMBER_BASE
      && cfg_wdata >= ritoa_pkg::BASE_MIN && cfg_wdata <= ritoa_pkg::BASE_MAX
      |=> cfg_r.base == $past(cfg_wdata))
    else $error("in-range radix write not stored");

endmodule

### src/ritoa_back.sv
// Back end: digit extraction by shared radix divider, digit store and reversed emission.
module ritoa_back #(
  parameter int MAX_DIGITS = 32,
  parameter int VALUE_BITS = 32
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  ritoa_pkg::cfg_t                    cfg,
  input  logic                               q_valid,
  input  logic [VALUE_BITS:0]                q_data,
  output logic                               q_pop,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [ritoa_pkg::CHAR_W-1:0]       out_char_code,
  output logic                               out_negative,
  output logic [ritoa_pkg::COUNT_W-1:0]      out_digit_count,
  output logic                               out_last
);

  localparam int NPH = (VALUE_BITS + ritoa_pkg::DIV_STEP - 1) / ritoa_pkg::DIV_STEP;
  localparam int DW  = NPH * ritoa_pkg::DIV_STEP;
  localparam int PW  = (NPH > 1) ? $clog2(NPH) : 1;
  localparam int AW  = $clog2(MAX_DIGITS);
  localparam int CW  = $clog2(MAX_DIGITS + 1);

  ritoa_pkg::back_state_t state_r, state_nxt;

  logic [DW-1:0]                 quo_r, quo_nxt;
  logic [ritoa_pkg::DIGIT_W-1:0] rem_r, rem_nxt;
  logic [PW-1:0]                 phase_r, phase_nxt;
  logic [CW-1:0]                 cnt_r, cnt_nxt;
  logic [AW-1:0]                 ptr_r, ptr_nxt;
  logic                          dv_r, dv_nxt;
  logic                          neg_r, neg_nxt;

  logic                          o_valid_r, o_valid_nxt;
  logic [ritoa_pkg::CHAR_W-1:0]  o_char_r, o_char_nxt;
  logic                          o_neg_r, o_neg_nxt;
  logic [ritoa_pkg::COUNT_W-1:0] o_cnt_r, o_cnt_nxt;
  logic                          o_last_r, o_last_nxt;

  logic [DW-1:0]                 div_quo;
  logic [ritoa_pkg::DIGIT_W-1:0] div_rem;
  logic                          phase_last;
  logic                          stop;
  logic                          load;

  logic                          ram_we;
  logic [AW-1:0]                 ram_raddr;
  logic [ritoa_pkg::DIGIT_W-1:0] ram_rdata;

  always_comb begin
    logic [DW-1:0]                 q;
    logic [ritoa_pkg::DIGIT_W-1:0] r;
    logic [ritoa_pkg::DIGIT_W:0]   t;
    q = quo_r;
    r = rem_r;
    for (int i = 0; i < ritoa_pkg::DIV_STEP; i++) begin
      t = {r, q[DW-1]};
      q = {q[DW-2:0], 1'b0};
      if (t >= {1'b0, cfg.base}) begin
        r    = ritoa_pkg::DIGIT_W'(t - {1'b0, cfg.base});
        q[0] = 1'b1;
      end else begin
        r = t[ritoa_pkg::DIGIT_W-1:0];
      end
    end
    div_quo = q;
    div_rem = r;
  end

  assign phase_last = (phase_r == PW'(NPH - 1));
  assign stop       = (div_quo == '0) || (cnt_r == CW'(MAX_DIGITS - 1));
  assign load       = (state_r == ritoa_pkg::BK_EMIT) && dv_r && (!o_valid_r || !out_stall);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ritoa_pkg::BK_IDLE: begin
        if (q_valid) begin
          state_nxt = ritoa_pkg::BK_DIV;
        end
      end
      ritoa_pkg::BK_DIV: begin
        if (phase_last && stop) begin
          state_nxt = ritoa_pkg::BK_EMIT;
        end
      end
      ritoa_pkg::BK_EMIT: begin
        if (load && ptr_r == '0) begin
          state_nxt = ritoa_pkg::BK_IDLE;
        end
      end
      default: state_nxt = ritoa_pkg::BK_IDLE;
    endcase
  end

  always_comb begin
    quo_nxt     = quo_r;
    rem_nxt     = rem_r;
    phase_nxt   = phase_r;
    cnt_nxt     = cnt_r;
    ptr_nxt     = ptr_r;
    dv_nxt      = dv_r;
    neg_nxt     = neg_r;
    q_pop       = 1'b0;
    ram_we      = 1'b0;
    ram_raddr   = ptr_r;
    o_valid_nxt = o_valid_r && out_stall;
    o_char_nxt  = o_char_r;
    o_neg_nxt   = o_neg_r;
    o_cnt_nxt   = o_cnt_r;
    o_last_nxt  = o_last_r;
    case (state_r)
      ritoa_pkg::BK_IDLE: begin
        if (q_valid) begin
          q_pop     = 1'b1;
          quo_nxt   = DW'(q_data[VALUE_BITS-1:0]);
          neg_nxt   = q_data[VALUE_BITS];
          rem_nxt   = '0;
          phase_nxt = '0;
          cnt_nxt   = '0;
        end
      end
      ritoa_pkg::BK_DIV: begin
        quo_nxt   = div_quo;
        rem_nxt   = div_rem;
        phase_nxt = phase_r + PW'(1);
        if (phase_last) begin
          ram_we    = 1'b1;
          rem_nxt   = '0;
          phase_nxt = '0;
          cnt_nxt   = cnt_r + CW'(1);
          ptr_nxt   = cnt_r[AW-1:0];
          dv_nxt    = 1'b0;
        end
      end
      ritoa_pkg::BK_EMIT: begin
        dv_nxt = 1'b1;
        if (load) begin
          ram_raddr   = ptr_r - AW'(1);
          ptr_nxt     = ptr_r - AW'(1);
          o_valid_nxt = 1'b1;
          o_char_nxt  = ritoa_pkg::glyph(ram_rdata);
          o_neg_nxt   = neg_r;
          o_cnt_nxt   = ritoa_pkg::COUNT_W'(cnt_r);
          o_last_nxt  = (ptr_r == '0);
        end
      end
      default: begin
        dv_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ritoa_pkg::BK_IDLE;
      o_valid_r <= 1'b0;
      dv_r      <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      o_valid_r <= o_valid_nxt;
      dv_r      <= dv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r    <= quo_nxt;
    rem_r    <= rem_nxt;
    phase_r  <= phase_nxt;
    cnt_r    <= cnt_nxt;
    ptr_r    <= ptr_nxt;
    neg_r    <= neg_nxt;
    o_char_r <= o_char_nxt;
    o_neg_r  <= o_neg_nxt;
    o_cnt_r  <= o_cnt_nxt;
    o_last_r <= o_last_nxt;
  end

  ritoa_ram #(
    .WIDTH (ritoa_pkg::DIGIT_W),
    .DEPTH (MAX_DIGITS)
  ) u_digit_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (cnt_r[AW-1:0]),
    .wdata (div_rem),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign out_valid       = o_valid_r;
  assign out_char_code   = o_char_r;
  assign out_negative    = o_neg_r;
  assign out_digit_count = o_cnt_r;
  assign out_last        = o_last_r;

  a_rem_below_base: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ritoa_pkg::BK_DIV |-> rem_r < cfg.base)
    else $error("partial remainder not below radix");

  a_cnt_in_store: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ritoa_pkg::BK_DIV |-> cnt_r < CW'(MAX_DIGITS))
    else $error("digit index beyond store");

  a_ptr_below_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ritoa_pkg::BK_EMIT |-> CW'(ptr_r) < cnt_r)
    else $error("read pointer beyond digit count");

  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> state_r == ritoa_pkg::BK_IDLE && q_valid)
    else $error("queue popped while busy");

endmodule

### src/radix_integer_to_ascii_unit.sv
// Top level of the radix integer-to-ASCII unit: front end, queue and back end.
// Flow: an item is registered into the queue; then, per digit, the shared 8-bit-per-cycle radix
// divider works through the value in 8-bit phases; then the digit store read is registered;
// then one digit goes out per cycle while out_stall is low. The back end takes one item at a
// time, and the two-entry queue lets the front end accept items while the back end is busy.
// Reset (synchronous, active low): radix 10, signed mode, queue and output empty.
module radix_integer_to_ascii_unit #(
  parameter int MAX_DIGITS = 32,
  parameter int VALUE_BITS = 32
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [ritoa_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ritoa_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [ritoa_pkg::IN_W-1:0]        in_value,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [ritoa_pkg::CHAR_W-1:0]      out_char_code,
  output logic                              out_negative,
  output logic [ritoa_pkg::COUNT_W-1:0]     out_digit_count,
  output logic                              out_last
);

  ritoa_pkg::cfg_t       cfg;
  logic                  push;
  logic [VALUE_BITS:0]   push_data;
  logic                  full;
  logic                  pop;
  logic                  pop_valid;
  logic [VALUE_BITS:0]   pop_data;

  ritoa_front #(
    .VALUE_BITS (VALUE_BITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_value  (in_value),
    .cfg       (cfg),
    .push      (push),
    .push_data (push_data),
    .full      (full)
  );

  ritoa_queue #(
    .WIDTH (VALUE_BITS + 1)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .pop_valid (pop_valid),
    .pop_data  (pop_data)
  );

  ritoa_back #(
    .MAX_DIGITS (MAX_DIGITS),
    .VALUE_BITS (VALUE_BITS)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg),
    .q_valid         (pop_valid),
    .q_data          (pop_data),
    .q_pop           (pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_char_code   (out_char_code),
    .out_negative    (out_negative),
    .out_digit_count (out_digit_count),
    .out_last        (out_last)
  );

endmodule
